// ----- rtl/core/txdc_pkg.sv -----
// Shared types, codes and float conversion functions for the XOR delta codec.
package txdc_pkg;

	typedef enum logic [1:0] {
		FMT_HALF  = 2'd0,
		FMT_F32   = 2'd1,
		FMT_INT64 = 2'd2,
		FMT_RSVD  = 2'd3
	} fmt_t;

	localparam logic       DIR_ENCODE = 1'b0;
	localparam logic       DIR_DECODE = 1'b1;
	localparam logic       OP_CODE    = 1'b0;
	localparam logic       OP_SEED    = 1'b1;
	localparam logic       REG_FORMAT = 1'b0;
	localparam logic       REG_DIR    = 1'b1;

	// float32 to float16, round to nearest even
	function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
		logic        s;
		logic [7:0]  e;
		logic [22:0] m;
		logic [14:0] r;
		logic [12:0] rem;
		logic [4:0]  sh;
		logic [23:0] fm;
		logic [23:0] q;
		logic [23:0] rm;
		logic [23:0] half;
		s  = x[31];
		e  = x[30:23];
		m  = x[22:0];
		r  = '0;
		rem = m[12:0];
		sh = '0;
		fm = {1'b1, m};
		q  = '0;
		rm = '0;
		half = '0;
		if (e == 8'hFF) begin
			if (m != '0)
				f32_to_f16 = {s, 5'h1F, 1'b1, m[21:13]};
			else
				f32_to_f16 = {s, 15'h7C00};
		end else if (e >= 8'd143) begin
			f32_to_f16 = {s, 15'h7C00};
		end else if (e >= 8'd113) begin
			r = {5'(e - 8'd112), m[22:13]};
			if (rem > 13'h1000 || (rem == 13'h1000 && r[0]))
				r = r + 15'd1;
			f32_to_f16 = {s, r};
		end else if (e < 8'd102) begin
			f32_to_f16 = {s, 15'd0};
		end else begin
			sh   = 5'(8'd126 - e);
			q    = fm >> sh;
			rm   = fm & ((24'd1 << sh) - 24'd1);
			half = 24'd1 << (sh - 5'd1);
			if (rm > half || (rm == half && q[0]))
				q = q + 24'd1;
			f32_to_f16 = {s, q[14:0]};
		end
	endfunction

	// float16 to float32, exact, NaN quieted
	function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] k;
		logic [9:0] nm;
		e  = h[14:10];
		m  = h[9:0];
		k  = '0;
		nm = '0;
		if (e == 5'h1F) begin
			if (m != '0)
				f16_to_f32 = {h[15], 8'hFF, 1'b1, m[8:0], 13'd0};
			else
				f16_to_f32 = {h[15], 8'hFF, 23'd0};
		end else if (e == 5'd0) begin
			if (m == '0) begin
				f16_to_f32 = {h[15], 31'd0};
			end else begin
				// leading one search: priority over ten bits
				for (int i = 0; i < 10; i++)
					if (m[i])
						k = 4'(9 - i);
				nm = m << (k + 4'd1);
				f16_to_f32 = {h[15], 8'(8'd112 - {4'd0, k}), nm, 13'd0};
			end
		end else begin
			f16_to_f32 = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
		end
	endfunction

endpackage

// ----- rtl/core/temporal_xor_delta_codec_top.sv -----
// Top level of the per-feature temporal XOR delta codec.
// Each beat names a feature and either seeds its stored previous value (no result) or codes one
// value against it (one result beat). Throughput is one beat per cycle unless the skid stage is
// full or the table is being cleared. The input register and the registered table read feed the
// conversion and XOR logic, whose result is loaded into an output register with a skid stage
// behind it. The per-feature table is a memory with registered read, written as the beat leaves
// the input register; a back-to-back beat for the same feature takes the new value through a
// forwarding register. After reset the table is cleared entry by entry, and s_axis_tready stays
// low until the clear is done. Features at or above FEATURE_COUNT are dropped silently.
module temporal_xor_delta_codec_top
	import txdc_pkg::*;
#(
	parameter int FEATURE_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // feature[5:0], value_bits[69:6], zero fill
	input  logic        s_axis_tuser,  // operation[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // result_bits[63:0], result_feature[69:64], zero fill
);

	localparam int IW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

	fmt_t fmt_q;
	logic dir_q;

	logic        vld_s1;
	logic        op_s1;
	logic [5:0]  feat_s1;
	logic [63:0] val_s1;
	logic [63:0] rd_s1;
	logic        byp_s1;
	logic [63:0] bdat_s1;

	logic [63:0]   prev_q [FEATURE_COUNT];
	logic          clr_q;
	logic [IW-1:0] clr_idx_q;
	logic [5:0]    in_feat;
	logic          rd;
	logic          st_wr;
	logic          wr;
	logic [IW-1:0] wr_addr;
	logic [63:0]   wr_data;

	logic        in_rng;
	logic [63:0] prev;
	logic [63:0] res;
	logic [63:0] nxt;
	logic [15:0] p16;
	logic [15:0] r16;
	logic        emit;

	logic        ovld_q, svld_q;
	logic [69:0] odat_q, sdat_q;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_HALF;
			dir_q <= DIR_ENCODE;
		end else if (cfg_we) begin
			if (cfg_index == REG_FORMAT)
				fmt_q <= fmt_t'(cfg_data);
			else
				dir_q <= cfg_data[0];
		end
	end

	// table clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == IW'(FEATURE_COUNT - 1))
				clr_q <= 1'b0;
			else
				clr_idx_q <= clr_idx_q + IW'(1);
		end
	end

	// input stage advances whenever the skid slot is free and the table clear is done
	assign s_axis_tready = !svld_q && !clr_q;
	assign adv = s_axis_tready;
	assign in_feat = s_axis_tdata[5:0];
	assign rd = adv && s_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			op_s1   <= s_axis_tuser;
			feat_s1 <= in_feat;
			val_s1  <= s_axis_tdata[69:6];
			// the beat leaving now writes the entry this beat has just read
			byp_s1  <= st_wr && (feat_s1 == in_feat);
			bdat_s1 <= nxt;
		end
	end

	assign st_wr   = adv && vld_s1 && in_rng;
	assign wr      = clr_q || st_wr;
	assign wr_addr = clr_q ? clr_idx_q : IW'(feat_s1);
	assign wr_data = clr_q ? '0 : nxt;

	always_ff @(posedge clk) begin
		if (wr)
			prev_q[wr_addr] <= wr_data;
		if (rd)
			rd_s1 <= prev_q[IW'(in_feat)];
	end

	assign in_rng = {26'd0, feat_s1} < 32'(FEATURE_COUNT);
	assign prev   = byp_s1 ? bdat_s1 : rd_s1;
	assign p16    = f32_to_f16(prev[31:0]);
	assign r16    = p16 ^ val_s1[15:0];

	always_comb begin
		res = '0;
		nxt = '0;
		if (op_s1 == OP_SEED) begin
			nxt = (fmt_q == FMT_HALF || fmt_q == FMT_F32) ? {32'd0, val_s1[31:0]} : val_s1;
		end else begin
			case (fmt_q)
				FMT_HALF: begin
					if (dir_q == DIR_ENCODE) begin
						res = {48'd0, f32_to_f16(val_s1[31:0]) ^ p16};
						nxt = {32'd0, val_s1[31:0]};
					end else begin
						res = {32'd0, f16_to_f32(r16)};
						nxt = res;
					end
				end
				FMT_F32: begin
					res = {32'd0, val_s1[31:0] ^ prev[31:0]};
					nxt = (dir_q == DIR_ENCODE) ? {32'd0, val_s1[31:0]} : res;
				end
				default: begin
					res = val_s1 ^ prev;
					nxt = (dir_q == DIR_ENCODE) ? val_s1 : res;
				end
			endcase
		end
	end

	assign emit = st_wr && (op_s1 == OP_CODE);

	// output register plus skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			svld_q <= 1'b0;
		end else begin
			if (!ovld_q || m_axis_tready) begin
				ovld_q <= svld_q || emit;
				svld_q <= 1'b0;
			end else if (emit) begin
				svld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ovld_q || m_axis_tready)
			odat_q <= svld_q ? sdat_q : {feat_s1, res};
		else if (emit)
			sdat_q <= {feat_s1, res};
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = {2'b00, odat_q};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n) svld_q |-> ovld_q)
		else $error("skid slot full with empty output register");
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		svld_q |-> !s_axis_tready) else $error("input accepted with skid full");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !m_axis_tready |=> ovld_q && $stable(odat_q))
		else $error("stalled result changed");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s_axis_tready) else $error("input accepted while clearing table");

endmodule
